/* rtl/core/cack_pkg.sv */
// ----------------------------------------------------------------------------
// Cumulative ack receiver package
// Shared widths, constants, controller states and control/status bundles.
// ----------------------------------------------------------------------------
package cack_pkg;

	localparam int SEQ_W         = 12;
	localparam int CNT_W         = 13;
	localparam int WORD_W        = 32;
	localparam int OFF_W         = $clog2(WORD_W);
	localparam int SEQ_SPACE_DEF = 4096;
	localparam int MAP_MAX       = 1 << SEQ_W;
	localparam logic [CNT_W-1:0] TOTAL_RST = CNT_W'(4096);

	typedef enum logic [6:0] {
		S_CLEAR   = 7'b0000001,
		S_IDLE    = 7'b0000010,
		S_READ    = 7'b0000100,
		S_WRITE   = 7'b0001000,
		S_SCAN_RD = 7'b0010000,
		S_SCAN    = 7'b0100000,
		S_DONE    = 7'b1000000
	} state_t;

	typedef struct packed {
		logic clr_wr;
		logic load_in;
		logic rd_seq;
		logic wr_set;
		logic rd_ne;
		logic scan;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic oor;
		logic hit;
		logic scan_more;
	} status_t;

endpackage

/* rtl/core/cack_seq_if.sv */
// ----------------------------------------------------------------------------
// Sequence number channel
// Valid/ready channel carrying one arriving sequence number per item.
// ----------------------------------------------------------------------------
interface cack_seq_if import cack_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [SEQ_W-1:0] seq_num;

	modport source (output valid, output seq_num, input ready);
	modport sink   (input valid, input seq_num, output ready);
endinterface

/* rtl/core/cack_ack_if.sv */
// ----------------------------------------------------------------------------
// Acknowledgement channel
// Valid/ready channel carrying the cumulative ack and status flags per item.
// ----------------------------------------------------------------------------
interface cack_ack_if import cack_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CNT_W-1:0] ack_value;
	logic             all_received;
	logic             out_of_range;

	modport source (output valid, output ack_value, output all_received,
		output out_of_range, input ready);
	modport sink   (input valid, input ack_value, input all_received,
		input out_of_range, output ready);
endinterface

/* rtl/core/cack_ctrl.sv */
// ----------------------------------------------------------------------------
// Cumulative ack receiver controller
// Sequences bitmap clear, mark, word scan and result hand-off.
// ----------------------------------------------------------------------------
module cack_ctrl import cack_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	input  status_t status,
	output cmd_t    cmd
);

	state_t state_q, state_nxt;
	logic   out_valid_q;

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (status.clr_last) begin
					state_nxt = S_IDLE;
				end
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_nxt   = S_READ;
				end
			end
			S_READ: begin
				if (status.oor) begin
					state_nxt = S_DONE;
				end else begin
					cmd.rd_seq = 1'b1;
					state_nxt  = S_WRITE;
				end
			end
			S_WRITE: begin
				cmd.wr_set = 1'b1;
				state_nxt  = status.hit ? S_SCAN_RD : S_DONE;
			end
			S_SCAN_RD: begin
				cmd.rd_ne = 1'b1;
				state_nxt = S_SCAN;
			end
			S_SCAN: begin
				cmd.scan  = 1'b1;
				state_nxt = status.scan_more ? S_SCAN_RD : S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

/* rtl/core/cack_dp.sv */
// ----------------------------------------------------------------------------
// Cumulative ack receiver datapath
// Received bitmap memory, expected-number register, word scan and result.
// ----------------------------------------------------------------------------
module cack_dp import cack_pkg::*; #(
	parameter int SEQ_SPACE = SEQ_SPACE_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CNT_W-1:0] cfg_wdata,
	input  logic [SEQ_W-1:0] seq_num,
	input  cmd_t             cmd,
	output status_t          status,
	output logic [CNT_W-1:0] ack_value,
	output logic             all_received,
	output logic             out_of_range
);

	localparam int MAP_DEPTH = (SEQ_SPACE < MAP_MAX) ? SEQ_SPACE : MAP_MAX;
	localparam int ROWS      = (MAP_DEPTH + WORD_W - 1) / WORD_W;
	localparam int ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int MAP_BITS  = ROWS * WORD_W;
	localparam int LIM_CAP   = (SEQ_SPACE > (1 << CNT_W) - 1) ? (1 << CNT_W) - 1 : SEQ_SPACE;

	logic [WORD_W-1:0] mem [ROWS];
	logic [WORD_W-1:0] rd_data_q;
	logic [ROW_W-1:0]  clr_row_q;
	logic [CNT_W-1:0]  total_q;
	logic [CNT_W-1:0]  ne_q;
	logic [SEQ_W-1:0]  seq_q;
	logic              oor_q;
	logic              hit_q;
	logic [CNT_W-1:0]  ack_q;
	logic              all_q;
	logic              oor_out_q;

	logic [CNT_W-1:0]  lim;
	logic [ROW_W-1:0]  rd_addr;
	logic              rd_en;
	logic [ROW_W-1:0]  wr_addr;
	logic [WORD_W-1:0] wr_data;
	logic              wr_en;
	logic [WORD_W-1:0] low_mask;
	logic [WORD_W-1:0] masked;
	logic [OFF_W-1:0]  zero_pos;
	logic              found;
	logic [CNT_W-1:0]  base;
	logic [CNT_W-1:0]  cand;
	logic [CNT_W-1:0]  new_ne;

	assign lim = (total_q > CNT_W'(LIM_CAP)) ? CNT_W'(LIM_CAP) : total_q;

	// memory port control
	assign rd_en   = cmd.rd_seq | cmd.rd_ne;
	assign rd_addr = cmd.rd_ne ? ne_q[OFF_W +: ROW_W] : seq_q[OFF_W +: ROW_W];
	assign wr_en   = cmd.clr_wr | cmd.wr_set;
	assign wr_addr = cmd.clr_wr ? clr_row_q : seq_q[OFF_W +: ROW_W];
	assign wr_data = cmd.clr_wr ? '0 :
		(rd_data_q | (WORD_W'(1) << seq_q[OFF_W-1:0]));

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// first clear bit at or above the current offset
	assign low_mask = (WORD_W'(1) << ne_q[OFF_W-1:0]) - WORD_W'(1);
	assign masked   = rd_data_q | low_mask;
	assign found    = ~&masked;

	always_comb begin
		zero_pos = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (!masked[i]) begin
				zero_pos = OFF_W'(i);
			end
		end
	end

	assign base   = ne_q & ~CNT_W'(WORD_W - 1);
	assign cand   = found ? (base | CNT_W'(zero_pos)) : (base + CNT_W'(WORD_W));
	assign new_ne = (cand > lim) ? lim : cand;

	assign status.clr_last  = (clr_row_q == ROW_W'(ROWS - 1));
	assign status.oor       = oor_q;
	assign status.hit       = hit_q;
	assign status.scan_more = !found && (cand < lim) && (cand < CNT_W'(MAP_BITS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q   <= TOTAL_RST;
			ne_q      <= '0;
			clr_row_q <= '0;
		end else begin
			if (cfg_we) begin
				total_q <= cfg_wdata;
			end
			if (cmd.clr_wr) begin
				clr_row_q <= clr_row_q + ROW_W'(1);
			end
			if (cmd.scan) begin
				ne_q <= new_ne;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			seq_q <= seq_num;
			oor_q <= ({1'b0, seq_num} >= lim);
			hit_q <= ({1'b0, seq_num} == ne_q);
		end
		if (cmd.load_out) begin
			ack_q     <= (hit_q && !oor_q) ? (ne_q - CNT_W'(1)) : ne_q;
			all_q     <= (ne_q >= lim);
			oor_out_q <= oor_q;
		end
	end

	assign ack_value    = ack_q;
	assign all_received = all_q;
	assign out_of_range = oor_out_q;

endmodule

/* rtl/core/cumulative_ack_receiver.sv */
// ----------------------------------------------------------------------------
// Cumulative ack receiver
// Receiver side of a sliding-window transfer with cumulative acknowledgement.
// ----------------------------------------------------------------------------
// One ack item per sequence number item, in order. The received bitmap sits
// in a single-port-per-direction memory of 32-bit rows; after reset the block
// clears it row by row (128 rows at the default space), taking no item
// meanwhile. An out-of-range number goes straight to the result; others have
// their row read and bit set, and the expected one then walks the map with a
// memory read and a scan per bitmap row crossed. A finished ack sits in an
// output register, so the next item is taken while it waits; the block stalls
// only if a second result is ready before the first has gone. The user must
// write total_count only while idle; the block itself does not enforce it.
module cumulative_ack_receiver import cack_pkg::*; #(
	parameter int SEQ_SPACE = SEQ_SPACE_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CNT_W-1:0] cfg_wdata,
	cack_seq_if.sink         in_ch,
	cack_ack_if.source       out_ch
);

	cmd_t    cmd;
	status_t status;

	cack_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.status    (status),
		.cmd       (cmd)
	);

	cack_dp #(
		.SEQ_SPACE (SEQ_SPACE)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.seq_num      (in_ch.seq_num),
		.cmd          (cmd),
		.status       (status),
		.ack_value    (out_ch.ack_value),
		.all_received (out_ch.all_received),
		.out_of_range (out_ch.out_of_range)
	);

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cumulative ack receiver testbench
// Drives sequence number items with bursty gaps against a stalling ack sink,
// predicts every ack from a local copy of the received map, next expected
// number and total count, and checks each ack field by field in order.
// ----------------------------------------------------------------------------
module tb import cack_pkg::*; ();

	typedef struct packed {
		logic [CNT_W-1:0] ack;
		logic             done;
		logic             oor;
	} ack_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CNT_W-1:0] cfg_wdata;

	cack_seq_if seq_ch ();
	cack_ack_if ack_ch ();

	cumulative_ack_receiver dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_ch     (seq_ch),
		.out_ch    (ack_ch)
	);

	// local copy of the receiver state
	bit               seen_map [SEQ_SPACE_DEF];
	logic [CNT_W-1:0] next_exp;
	logic [CNT_W-1:0] count_reg;

	ack_t pending_acks[$];
	int   errors;
	int   items_sent;
	int   acks_checked;
	int   oor_seen;
	int   done_seen;
	int   counts_written;
	int   burst_left;
	int   stall_cnt;
	int   stall_mode;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic ack_t predict_ack(input logic [SEQ_W-1:0] s);
		ack_t             r;
		logic [CNT_W-1:0] lim;
		lim = (count_reg > CNT_W'(SEQ_SPACE_DEF)) ? CNT_W'(SEQ_SPACE_DEF) : count_reg;
		r.oor = 1'b0;
		if ({1'b0, s} >= lim) begin
			r.oor = 1'b1;
			r.ack = next_exp;
		end else if ({1'b0, s} == next_exp) begin
			seen_map[s] = 1'b1;
			while (next_exp < lim && seen_map[next_exp[SEQ_W-1:0]])
				next_exp = next_exp + 1'b1;
			r.ack = next_exp - 1'b1;
		end else begin
			seen_map[s] = 1'b1;
			r.ack = next_exp;
		end
		r.done = (next_exp >= lim);
		return r;
	endfunction

	// receiver stall pattern, in a randomly redrawn mode
	initial begin
		ack_ch.ready = 1'b0;
		stall_mode = 0;
		stall_cnt = 0;
		forever begin
			@(negedge clk);
			stall_cnt++;
			if (stall_cnt % 64 == 0)
				stall_mode = $urandom_range(0, 3);
			case (stall_mode)
				0: ack_ch.ready <= 1'b1;
				1: ack_ch.ready <= 1'($urandom_range(0, 1));
				2: ack_ch.ready <= ($urandom_range(0, 3) == 0);
				default: ack_ch.ready <= stall_cnt[3];
			endcase
		end
	end

	always @(posedge clk) begin
		ack_t e;
		if (arst_n && ack_ch.valid && ack_ch.ready) begin
			if (pending_acks.size() == 0) begin
				$display("%0t: unexpected ack item, ack_value %0d", $time,
					ack_ch.ack_value);
				errors++;
			end else begin
				e = pending_acks.pop_front();
				acks_checked++;
				if (e.oor)
					oor_seen++;
				if (e.done)
					done_seen++;
				if (ack_ch.ack_value !== e.ack) begin
					$display("%0t: ack_value expected %0d, got %0d", $time,
						e.ack, ack_ch.ack_value);
					errors++;
				end
				if (ack_ch.all_received !== e.done) begin
					$display("%0t: all_received expected %0b, got %0b", $time,
						e.done, ack_ch.all_received);
					errors++;
				end
				if (ack_ch.out_of_range !== e.oor) begin
					$display("%0t: out_of_range expected %0b, got %0b", $time,
						e.oor, ack_ch.out_of_range);
					errors++;
				end
			end
		end
	end

	initial begin
		#20_000_000;
		$display("%0t: timeout, %0d acks outstanding", $time, pending_acks.size());
		$display("cumulative_ack_receiver test failed");
		$finish;
	end

	// called at a falling edge, returns at a falling edge
	task automatic send_seq(input logic [SEQ_W-1:0] s);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				seq_ch.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		seq_ch.valid <= 1'b1;
		seq_ch.seq_num <= s;
		do @(posedge clk); while (!seq_ch.ready);
		pending_acks.push_back(predict_ack(s));
		burst_left--;
		items_sent++;
		@(negedge clk);
	endtask

	task automatic wait_idle();
		seq_ch.valid <= 1'b0;
		while (pending_acks.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic set_total(input logic [CNT_W-1:0] v);
		wait_idle();
		cfg_wdata <= v;
		cfg_we <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
		count_reg = v;
		counts_written++;
	endtask

	task automatic test_default_window();
		send_seq(SEQ_W'(0));
		send_seq(SEQ_W'(4095));
		send_seq(SEQ_W'(2));
		send_seq(SEQ_W'(1));
		send_seq(SEQ_W'(2));
		send_seq(SEQ_W'(0));
		send_seq(SEQ_W'(4));
		send_seq(SEQ_W'('hAAA));
		send_seq(SEQ_W'('h555));
		send_seq(SEQ_W'(3));
	endtask

	task automatic test_zero_count();
		set_total(CNT_W'(0));
		send_seq(SEQ_W'(0));
		send_seq(SEQ_W'(4095));
		send_seq(next_exp[SEQ_W-1:0]);
	endtask

	task automatic test_saturated_count();
		set_total(CNT_W'(8191));
		send_seq(SEQ_W'(4095));
		send_seq(next_exp[SEQ_W-1:0]);
		set_total(CNT_W'(4097));
		send_seq(next_exp[SEQ_W-1:0]);
	endtask

	// transfer completes, then keeps taking items
	task automatic test_small_count();
		logic [SEQ_W-1:0] n;
		n = next_exp[SEQ_W-1:0];
		set_total(next_exp + 2'd2);
		send_seq(n + 1'b1);
		send_seq(n);
		send_seq(n + 1'b1);
		send_seq(n + 2'd2);
		send_seq(SEQ_W'(4095));
	endtask

	// limit below next expected: no walk
	task automatic test_lowered_count();
		set_total(CNT_W'(1));
		send_seq(SEQ_W'(0));
		send_seq(SEQ_W'(1));
		set_total(CNT_W'(4096));
		send_seq(next_exp[SEQ_W-1:0]);
	endtask

	// windows of in-order-ish numbers with reordering, losses and noise
	task automatic test_random_windows();
		logic [SEQ_W-1:0] plan[$];
		logic [SEQ_W-1:0] tmp;
		logic [CNT_W-1:0] tot;
		logic [CNT_W-1:0] lim;
		int               start, w, hi, j, idx, sent0;
		sent0 = items_sent;
		while (items_sent - sent0 < 830) begin
			start = next_exp;
			w = ($urandom_range(0, 7) == 0) ? $urandom_range(121, 320) : $urandom_range(1, 120);
			hi = start + w;
			if (hi > SEQ_SPACE_DEF)
				hi = SEQ_SPACE_DEF;
			case ($urandom_range(0, 9))
				0: tot = CNT_W'($urandom_range(0, 8191));
				1, 2: tot = CNT_W'(hi + $urandom_range(0, 40));
				default: tot = CNT_W'(hi);
			endcase
			set_total(tot);
			lim = (count_reg > CNT_W'(SEQ_SPACE_DEF)) ? CNT_W'(SEQ_SPACE_DEF) : count_reg;
			plan.delete();
			for (j = start; j < hi; j++)
				plan.push_back(SEQ_W'(j));
			for (j = 0; j < plan.size(); j++) begin
				idx = j + $urandom_range(0, 7);
				if (idx < plan.size()) begin
					tmp = plan[j];
					plan[j] = plan[idx];
					plan[idx] = tmp;
				end
			end
			if (plan.size() == 0) begin
				repeat (20)
					send_seq(SEQ_W'($urandom));
			end
			for (j = 0; j < plan.size() && items_sent - sent0 < 830; j++) begin
				if ($urandom_range(0, 6) == 0) begin
					case ($urandom_range(0, 2))
						0: send_seq((next_exp > 0) ?
							SEQ_W'($urandom_range(0, next_exp - 1)) : SEQ_W'($urandom));
						1: send_seq((lim < CNT_W'(SEQ_SPACE_DEF)) ?
							SEQ_W'($urandom_range(lim, 4095)) : SEQ_W'($urandom));
						default: send_seq(SEQ_W'($urandom));
					endcase
				end
				// lost item, resent at the end of the window
				if ($urandom_range(0, 19) == 0 && j < plan.size() - 1)
					plan.push_back(plan[j]);
				else
					send_seq(plan[j]);
			end
		end
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		seq_ch.valid = 1'b0;
		seq_ch.seq_num = '0;
		next_exp = '0;
		count_reg = TOTAL_RST;
		errors = 0;
		items_sent = 0;
		acks_checked = 0;
		oor_seen = 0;
		done_seen = 0;
		counts_written = 0;
		burst_left = 0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_default_window();
		test_zero_count();
		test_saturated_count();
		test_small_count();
		test_lowered_count();
		test_random_windows();

		wait_idle();
		repeat (20) @(negedge clk);
		$display("Sent %0d sequence items over %0d total_count settings; %0d acks checked.",
			items_sent, counts_written, acks_checked);
		$display("%0d acks flagged out of range, %0d with transfer complete, next expected %0d.",
			oor_seen, done_seen, next_exp);
		if (errors == 0)
			$display("cumulative_ack_receiver test passed");
		else
			$display("cumulative_ack_receiver test failed");
		$finish;
	end

endmodule
